>>> design/rpb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpb_pkg
// Shared types and constants for the blocked-list random picker.
// ----------------------------------------------------------------------------
package rpb_pkg;

  localparam int MAX_BLOCKED_DEF = 256;
  localparam int TABLE_DEPTH_DEF = 512;
  localparam int VW = 31;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_PICK = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic          req_type;
    logic [VW-1:0] blocked_value;
    logic          last_entry;
    logic [31:0]   random_word;
  } in_word_t;

  typedef struct packed {
    logic [VW-1:0] picked_value;
    logic [1:0]    status;
  } out_word_t;

  // one hash table slot
  typedef struct packed {
    logic          used;
    logic          blocked;
    logic [VW-1:0] key;
    logic [VW-1:0] target;
  } slot_t;

endpackage

>>> design/rpb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpb_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rpb_ram #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> design/rpb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpb_front
// Input side: takes words off the channel into a two-entry queue.
// ----------------------------------------------------------------------------
module rpb_front
  import rpb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     hold,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_word_t in_data,
  output logic     q_valid,
  output in_word_t q_data,
  input  logic     q_pop
);

  in_word_t   buf_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign in_ready = (cnt_r != 2'd2) && !hold;
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = buf_r[rp_r];

  always_comb begin
    wp_nxt  = push  ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r] <= in_data;
    end
  end

endmodule

>>> design/rpb_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpb_engine
// Back end: hash table probes, remap walk, modulo unit and result register.
// ----------------------------------------------------------------------------
module rpb_engine
  import rpb_pkg::*;
#(
  parameter int MAX_BLOCKED = MAX_BLOCKED_DEF,
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [VW-1:0] cfg_wdata,
  input  logic          q_valid,
  input  in_word_t      q_data,
  output logic          q_pop,
  output logic          init_busy,
  output logic          out_valid,
  input  logic          out_ready,
  output out_word_t     out_data
);

  localparam int TAW = $clog2(TABLE_DEPTH);
  localparam int LAW = (MAX_BLOCKED > 1) ? $clog2(MAX_BLOCKED) : 1;
  localparam int CW  = $clog2(MAX_BLOCKED + 1);
  localparam int SW  = $bits(slot_t);
  localparam logic [TAW-1:0] TLAST = TAW'(TABLE_DEPTH - 1);
  localparam logic [CW-1:0]  CMAX  = CW'(MAX_BLOCKED);

  localparam logic [3:0] S_CLR     = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_LD_CHK  = 4'd2;
  localparam logic [3:0] S_LD_PRB  = 4'd3;
  localparam logic [3:0] S_LD_TAIL = 4'd4;
  localparam logic [3:0] S_W_NEXT  = 4'd5;
  localparam logic [3:0] S_W_B     = 4'd6;
  localparam logic [3:0] S_W_SCAN  = 4'd7;
  localparam logic [3:0] S_W_SRES  = 4'd8;
  localparam logic [3:0] S_W_MAP   = 4'd9;
  localparam logic [3:0] S_DIV     = 4'd10;
  localparam logic [3:0] S_PK_RES  = 4'd11;
  localparam logic [3:0] S_EMIT    = 4'd12;
  localparam logic [3:0] S_PR_ISS  = 4'd13;
  localparam logic [3:0] S_PR_CHK  = 4'd14;

  logic [3:0]     state_r, state_nxt, ret_r, ret_nxt;
  logic [VW-1:0]  range_r;
  in_word_t       it_r, it_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [VW-1:0]  good_r, good_nxt;
  logic           built_r, built_nxt;
  logic           init_r, init_nxt;
  logic           clr_ld_r, clr_ld_nxt;
  logic [TAW-1:0] clr_r, clr_nxt;
  logic [VW-1:0]  m_r, m_nxt;
  logic [31:0]    last_r, last_nxt;
  logic [CW-1:0]  i_r, i_nxt;
  logic [VW-1:0]  b_r, b_nxt;
  logic [VW-1:0]  pk_r, pk_nxt;
  logic [1:0]     st_r, st_nxt;
  // probe unit
  logic [VW-1:0]  pkey_r, pkey_nxt;
  logic [TAW-1:0] pidx_r, pidx_nxt, pcnt_r, pcnt_nxt;
  logic           pfound_r, pfound_nxt, pfull_r, pfull_nxt;
  slot_t          pword_r, pword_nxt;
  // modulo unit
  logic [VW-1:0]  rem_r, rem_nxt;
  logic [31:0]    dvd_r, dvd_nxt;
  logic [4:0]     dcnt_r, dcnt_nxt;
  logic [31:0]    trial;
  // output register
  logic           ov_r, ov_nxt;
  out_word_t      od_r, od_nxt;
  // memories
  logic           tab_we, lst_we;
  logic [TAW-1:0] tab_waddr;
  slot_t          tab_wdata, tab_rdata;
  logic [SW-1:0]  tab_rraw;
  logic [LAW-1:0] lst_raddr;
  logic [VW-1:0]  lst_rdata;
  logic [CW:0]    m_diff;

  rpb_ram #(.W(SW), .D(TABLE_DEPTH)) u_tab (
    .clk(clk), .we(tab_we), .waddr(tab_waddr), .wdata(tab_wdata),
    .raddr(pidx_r), .rdata(tab_rraw)
  );
  assign tab_rdata = slot_t'(tab_rraw);

  rpb_ram #(.W(VW), .D(MAX_BLOCKED)) u_lst (
    .clk(clk), .we(lst_we), .waddr(cnt_r[LAW-1:0]), .wdata(it_r.blocked_value),
    .raddr(lst_raddr), .rdata(lst_rdata)
  );

  assign lst_raddr = i_r[LAW-1:0];
  assign trial     = {rem_r, dvd_r[31]};
  assign m_diff    = {1'b0, cnt_r};

  assign init_busy = init_r;
  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_comb begin
    state_nxt  = state_r;  ret_nxt   = ret_r;    it_nxt    = it_r;
    cnt_nxt    = cnt_r;    good_nxt  = good_r;   built_nxt = built_r;
    init_nxt   = init_r;   clr_ld_nxt = clr_ld_r; clr_nxt  = clr_r;
    m_nxt      = m_r;      last_nxt  = last_r;   i_nxt     = i_r;
    b_nxt      = b_r;      pk_nxt    = pk_r;     st_nxt    = st_r;
    pkey_nxt   = pkey_r;   pidx_nxt  = pidx_r;   pcnt_nxt  = pcnt_r;
    pfound_nxt = pfound_r; pfull_nxt = pfull_r;  pword_nxt = pword_r;
    rem_nxt    = rem_r;    dvd_nxt   = dvd_r;    dcnt_nxt  = dcnt_r;
    ov_nxt     = ov_r && !out_ready;
    od_nxt     = od_r;
    q_pop      = 1'b0;
    tab_we     = 1'b0;
    tab_waddr  = pidx_r;
    tab_wdata  = '0;
    lst_we     = 1'b0;

    unique case (state_r)
      S_CLR: begin
        tab_we    = 1'b1;
        tab_waddr = clr_r;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == TLAST) begin
          init_nxt  = 1'b0;
          state_nxt = clr_ld_r ? S_LD_CHK : S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop  = 1'b1;
          it_nxt = q_data;
          pk_nxt = '0;
          st_nxt = ST_OK;
          if (q_data.req_type == REQ_LOAD) begin
            if (built_r) begin
              cnt_nxt    = '0;
              good_nxt   = '0;
              built_nxt  = 1'b0;
              clr_nxt    = '0;
              clr_ld_nxt = 1'b1;
              state_nxt  = S_CLR;
            end else begin
              state_nxt = S_LD_CHK;
            end
          end else if (!built_r || good_r == '0) begin
            st_nxt    = ST_EMPTY;
            state_nxt = S_EMIT;
          end else begin
            rem_nxt   = '0;
            dvd_nxt   = q_data.random_word;
            dcnt_nxt  = '0;
            state_nxt = S_DIV;
          end
        end
      end
      S_LD_CHK: begin
        if (it_r.blocked_value >= range_r) begin
          st_nxt    = ST_RANGE;
          state_nxt = S_LD_TAIL;
        end else begin
          pkey_nxt  = it_r.blocked_value;
          pidx_nxt  = it_r.blocked_value[TAW-1:0];
          pcnt_nxt  = '0;
          ret_nxt   = S_LD_PRB;
          state_nxt = S_PR_ISS;
        end
      end
      S_LD_PRB: begin
        if (!pfound_r) begin
          if (cnt_r >= CMAX || pfull_r) begin
            st_nxt = ST_FULL;
          end else begin
            tab_we            = 1'b1;
            tab_wdata.used    = 1'b1;
            tab_wdata.blocked = 1'b1;
            tab_wdata.key     = it_r.blocked_value;
            lst_we            = 1'b1;
            cnt_nxt           = cnt_r + 1'b1;
          end
        end
        state_nxt = S_LD_TAIL;
      end
      S_LD_TAIL: begin
        if (it_r.last_entry) begin
          // M = n - k, or zero when the range has shrunk below the count
          m_nxt     = ({{(VW-CW-1){1'b0}}, m_diff} > {1'b0, range_r}) ? '0
                      : range_r - VW'(cnt_r);
          last_nxt  = {1'b0, range_r} - 32'd1;
          i_nxt     = '0;
          state_nxt = S_W_NEXT;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_W_NEXT: begin
        if (i_r < cnt_r) begin
          state_nxt = S_W_B;
        end else begin
          good_nxt  = m_r;
          built_nxt = 1'b1;
          state_nxt = S_EMIT;
        end
      end
      S_W_B: begin
        b_nxt = lst_rdata;
        if (lst_rdata >= m_r) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_W_NEXT;
        end else begin
          state_nxt = S_W_SCAN;
        end
      end
      S_W_SCAN: begin
        if ($signed(last_r) >= $signed({1'b0, m_r})) begin
          pkey_nxt  = last_r[VW-1:0];
          pidx_nxt  = last_r[TAW-1:0];
          pcnt_nxt  = '0;
          ret_nxt   = S_W_SRES;
          state_nxt = S_PR_ISS;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_W_NEXT;
        end
      end
      S_W_SRES: begin
        if (pfound_r && pword_r.blocked) begin
          last_nxt  = last_r - 32'd1;
          state_nxt = S_W_SCAN;
        end else begin
          pkey_nxt  = b_r;
          pidx_nxt  = b_r[TAW-1:0];
          pcnt_nxt  = '0;
          ret_nxt   = S_W_MAP;
          state_nxt = S_PR_ISS;
        end
      end
      S_W_MAP: begin
        if (pfound_r) begin
          tab_we            = 1'b1;
          tab_wdata         = pword_r;
          tab_wdata.blocked = 1'b0;
          tab_wdata.target  = last_r[VW-1:0];
        end
        last_nxt  = last_r - 32'd1;
        i_nxt     = i_r + 1'b1;
        state_nxt = S_W_NEXT;
      end
      S_DIV: begin
        // restoring remainder, one dividend bit a cycle
        if (trial >= {1'b0, good_r}) begin
          rem_nxt = VW'(trial - {1'b0, good_r});
        end else begin
          rem_nxt = trial[VW-1:0];
        end
        dvd_nxt  = {dvd_r[30:0], 1'b0};
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == 5'd31) begin
          pkey_nxt  = rem_nxt;
          pidx_nxt  = rem_nxt[TAW-1:0];
          pcnt_nxt  = '0;
          ret_nxt   = S_PK_RES;
          state_nxt = S_PR_ISS;
        end
      end
      S_PK_RES: begin
        pk_nxt    = (pfound_r && !pword_r.blocked) ? pword_r.target : pkey_r;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          od_nxt    = '{picked_value: pk_r, status: st_r};
          state_nxt = S_IDLE;
        end
      end
      S_PR_ISS: begin
        state_nxt = S_PR_CHK;
      end
      S_PR_CHK: begin
        pword_nxt = tab_rdata;
        if (!tab_rdata.used) begin
          pfound_nxt = 1'b0;
          pfull_nxt  = 1'b0;
          state_nxt  = ret_r;
        end else if (tab_rdata.key == pkey_r) begin
          pfound_nxt = 1'b1;
          pfull_nxt  = 1'b0;
          state_nxt  = ret_r;
        end else if (pcnt_r == TLAST) begin
          pfound_nxt = 1'b0;
          pfull_nxt  = 1'b1;
          state_nxt  = ret_r;
        end else begin
          pidx_nxt  = pidx_r + 1'b1;
          pcnt_nxt  = pcnt_r + 1'b1;
          state_nxt = S_PR_ISS;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      init_r   <= 1'b1;
      clr_ld_r <= 1'b0;
      clr_r    <= '0;
      cnt_r    <= '0;
      good_r   <= '0;
      built_r  <= 1'b0;
      ov_r     <= 1'b0;
      range_r  <= VW'(1);
    end else begin
      state_r  <= state_nxt;
      init_r   <= init_nxt;
      clr_ld_r <= clr_ld_nxt;
      clr_r    <= clr_nxt;
      cnt_r    <= cnt_nxt;
      good_r   <= good_nxt;
      built_r  <= built_nxt;
      ov_r     <= ov_nxt;
      if (cfg_we) begin
        range_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    ret_r    <= ret_nxt;   it_r    <= it_nxt;    m_r      <= m_nxt;
    last_r   <= last_nxt;  i_r     <= i_nxt;     b_r      <= b_nxt;
    pk_r     <= pk_nxt;    st_r    <= st_nxt;    pkey_r   <= pkey_nxt;
    pidx_r   <= pidx_nxt;  pcnt_r  <= pcnt_nxt;  pfound_r <= pfound_nxt;
    pfull_r  <= pfull_nxt; pword_r <= pword_nxt; rem_r    <= rem_nxt;
    dvd_r    <= dvd_nxt;   dcnt_r  <= dcnt_nxt;  od_r     <= od_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CMAX) else $error("blocked count past list depth");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == S_IDLE)) else $error("queue popped while busy");

  a_div_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (built_r && good_r != '0)) else $error("modulo by zero");

endmodule

>>> design/random_pick_with_blacklist_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// random_pick_with_blacklist_top
// Blocked-list loader and random picker on a linear-probing hash table.
// ----------------------------------------------------------------------------
// Pick: a restoring remainder unit reduces the random word, then a hash probe.
// Load: a range check, then a probe for the value; the last load adds the remap
//   walk over the list entries plus their probes. One word in the engine at a time.
// A load after a finished table first sweeps all TABLE_DEPTH slots to clear it.
// Reset (rst_n low, synchronous) starts a clearing pass over all TABLE_DEPTH slots;
//   in_ready stays low until it ends.
module random_pick_with_blacklist_top
  import rpb_pkg::*;
#(
  parameter int MAX_BLOCKED = MAX_BLOCKED_DEF,
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [VW-1:0] cfg_wdata,
  input  logic          in_valid,
  output logic          in_ready,
  input  in_word_t      in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output out_word_t     out_data
);

  logic     q_valid, q_pop, init_busy;
  in_word_t q_data;

  rpb_front u_front (
    .clk(clk), .rst_n(rst_n), .hold(init_busy),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
  );

  rpb_engine #(.MAX_BLOCKED(MAX_BLOCKED), .TABLE_DEPTH(TABLE_DEPTH)) u_engine (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop), .init_busy(init_busy),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives load and pick words into the blocked-list random picker, predicts
// every result with an independent hash-table model and checks each output
// word in order. Random gaps on both sides, one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import rpb_pkg::*;

  localparam int NBLK = 256;
  localparam int TDEP = 512;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [VW-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;

  random_pick_with_blacklist_top uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [VW-1:0] p_range;
  logic [VW-1:0] p_key [TDEP];
  logic [VW-1:0] p_tgt [TDEP];
  bit p_used [TDEP];
  bit p_blk [TDEP];
  logic [VW-1:0] p_list [NBLK];
  int unsigned p_count;
  logic [VW-1:0] p_good;
  bit p_built;

  in_word_t pending_words[$];
  out_word_t expected_words[$];
  int errors = 0;
  int accepted_in = 0;
  int hold_cycles = 0;
  bit rx_done_hold = 0;

  function automatic int probe_slot(input logic [VW-1:0] key, output bit hit);
    int idx;
    idx = key % TDEP;
    hit = 0;
    for (int n = 0; n < TDEP; n++) begin
      if (!p_used[idx]) return idx;
      if (p_key[idx] == key) begin
        hit = 1;
        return idx;
      end
      idx = (idx + 1) % TDEP;
    end
    return TDEP;
  endfunction

  task automatic clear_table();
    for (int i = 0; i < TDEP; i++) begin
      p_used[i] = 0;
      p_blk[i] = 0;
      p_tgt[i] = '0;
      p_key[i] = '0;
    end
    p_count = 0;
    p_good = '0;
    p_built = 0;
  endtask

  task automatic remap_blocked();
    longint top;
    longint m;
    int s;
    bit hit;
    m = (p_count > p_range) ? 0 : longint'(p_range) - p_count;
    top = longint'(p_range) - 1;
    for (int i = 0; i < p_count; i++) begin
      if (p_list[i] >= m) continue;
      while (top >= m) begin
        s = probe_slot(top[VW-1:0], hit);
        if (hit && p_blk[s]) top--;
        else break;
      end
      if (top < m) continue;
      s = probe_slot(p_list[i], hit);
      if (hit && s < TDEP) begin
        p_tgt[s] = top[VW-1:0];
        p_blk[s] = 0;
      end
      top--;
    end
    p_good = m[VW-1:0];
    p_built = 1;
  endtask

  task automatic predict_word(input in_word_t w);
    out_word_t r;
    int s;
    bit hit;
    longint unsigned idx;
    r = '0;
    r.status = ST_OK;
    if (w.req_type == REQ_LOAD) begin
      if (p_built) clear_table();
      if (w.blocked_value >= p_range) r.status = ST_RANGE;
      else begin
        s = probe_slot(w.blocked_value, hit);
        if (!hit) begin
          if (p_count >= NBLK || s >= TDEP) r.status = ST_FULL;
          else begin
            p_key[s] = w.blocked_value;
            p_tgt[s] = '0;
            p_used[s] = 1;
            p_blk[s] = 1;
            p_list[p_count] = w.blocked_value;
            p_count++;
          end
        end
      end
      if (w.last_entry) remap_blocked();
    end else begin
      if (!p_built || p_good == 0) r.status = ST_EMPTY;
      else begin
        idx = w.random_word % p_good;
        s = probe_slot(idx[VW-1:0], hit);
        if (hit && s < TDEP && !p_blk[s]) r.picked_value = p_tgt[s];
        else r.picked_value = idx[VW-1:0];
      end
    end
    expected_words.push_back(r);
  endtask

  // driver
  int tx_gap = 0;
  always @(posedge clk) begin
    if (in_valid && in_ready) begin
      predict_word(in_data);
      accepted_in++;
    end
    if (in_valid && !in_ready) begin
    end else if (tx_gap > 0) begin
      in_valid <= 1'b0;
      tx_gap <= tx_gap - 1;
    end else if (rst_n && pending_words.size() > 0) begin
      in_data <= pending_words.pop_front();
      in_valid <= 1'b1;
      tx_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (!rx_done_hold && accepted_in > 300) begin
      hold_cycles <= hold_cycles + 1;
      if (hold_cycles >= 400) rx_done_hold <= 1;
    end
  end

  // monitor
  int rx_gap = 0;
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word %h", out_data);
      end else if (out_data !== expected_words[0]) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp value %0d status %0d, got value %0d status %0d",
                   expected_words[0].picked_value, expected_words[0].status,
                   out_data.picked_value, out_data.status);
        void'(expected_words.pop_front());
      end else begin
        void'(expected_words.pop_front());
      end
    end
    if (!rx_done_hold && accepted_in > 300) begin
      out_ready <= 1'b0;
    end else if (rx_gap > 0) begin
      out_ready <= 1'b0;
      rx_gap <= rx_gap - 1;
    end else begin
      out_ready <= 1'b1;
      if (out_valid && out_ready && $urandom_range(0, 3) == 0)
        rx_gap <= $urandom_range(0, 17);
    end
  end

  function automatic in_word_t make_load(input logic [VW-1:0] v, input bit last);
    in_word_t w;
    w = '0;
    w.req_type = REQ_LOAD;
    w.blocked_value = v;
    w.last_entry = last;
    w.random_word = $urandom();
    return w;
  endfunction

  function automatic in_word_t make_pick(input logic [31:0] r);
    in_word_t w;
    w.req_type = REQ_PICK;
    w.blocked_value = VW'($urandom());
    w.last_entry = 1'($urandom_range(0, 1));
    w.random_word = r;
    return w;
  endfunction

  task automatic wait_idle();
    while (pending_words.size() > 0 || in_valid || expected_words.size() > 0)
      @(posedge clk);
    repeat (2 * TDEP + 1200) @(posedge clk);
  endtask

  task automatic set_range(input logic [VW-1:0] n);
    cfg_we <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we <= 1'b0;
    p_range = n;
    @(posedge clk);
  endtask

  initial begin
    logic [VW-1:0] n;
    int k;
    p_range = 31'd1;
    clear_table();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (TDEP + 20) @(posedge clk);
    // directed: pick before any load, default range of one
    pending_words.push_back(make_pick(32'hFFFF_FFFF));
    pending_words.push_back(make_load(31'd0, 1'b1));   // range emptied
    pending_words.push_back(make_pick(32'h0));
    wait_idle();
    set_range(31'd10);
    pending_words.push_back(make_load(31'd9, 1'b0));
    pending_words.push_back(make_load(31'd2, 1'b0));
    pending_words.push_back(make_load(31'd2, 1'b0));   // duplicate
    pending_words.push_back(make_load(31'h7FFF_FFFE, 1'b0)); // out of range
    pending_words.push_back(make_load(31'd8, 1'b1));
    pending_words.push_back(make_pick(32'h0));
    pending_words.push_back(make_pick(32'hFFFF_FFFF));
    pending_words.push_back(make_pick(32'h5));
    wait_idle();
    set_range(31'h7FFF_FFFF);
    pending_words.push_back(make_load(31'h7FFF_FFFE, 1'b0));
    pending_words.push_back(make_load(31'd0, 1'b0));
    pending_words.push_back(make_load(31'd512, 1'b1)); // same hash slot as 0
    pending_words.push_back(make_pick(32'hFFFF_FFFF));
    pending_words.push_back(make_pick(32'h0));
    wait_idle();
    // list full: more than 256 distinct values, then shrink range mid-load
    set_range(31'd400);
    for (int i = 0; i < 260; i++) pending_words.push_back(make_load(VW'(i), i == 259));
    for (int i = 0; i < 20; i++) pending_words.push_back(make_pick($urandom()));
    wait_idle();
    set_range(31'd300);
    for (int i = 0; i < 5; i++) pending_words.push_back(make_load(VW'(i * 3), 1'b0));
    wait_idle();
    set_range(31'd3);
    pending_words.push_back(make_load(31'd0, 1'b1));
    pending_words.push_back(make_pick($urandom()));
    wait_idle();
    // random phases
    for (int ph = 0; ph < 14; ph++) begin
      case (ph % 4)
        0: n = VW'($urandom_range(1, 40));
        1: n = VW'($urandom_range(1, 1000));
        2: n = VW'($urandom());
        default: n = 31'h7FFF_FFFF - VW'($urandom_range(0, 3));
      endcase
      if (n == 0) n = 31'd1;
      set_range(n);
      k = $urandom_range(0, 20);
      for (int i = 0; i < k; i++)
        pending_words.push_back(make_load(
          ($urandom_range(0, 9) == 0) ? VW'($urandom()) : VW'($urandom_range(0, n - 1)),
          i == k - 1));
      if (k == 0) pending_words.push_back(make_load(VW'($urandom() % n), 1'b1));
      for (int i = 0; i < 90; i++)
        pending_words.push_back(($urandom_range(0, 19) == 0) ?
          make_load(VW'($urandom() % n), 1'($urandom_range(0, 1))) :
          make_pick($urandom()));
      wait_idle();
    end
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #40ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> filelist.f
design/rpb_pkg.sv
design/rpb_ram.sv
design/rpb_front.sv
design/rpb_engine.sv
design/random_pick_with_blacklist_top.sv
dv/testbench.sv
